/* rtl/dldc_pkg.sv */
// Package for the two-channel cold/warm LED dimmer.
// Holds command and preset codes, the controller state struct and the percent-to-duty table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dldc_pkg;

    localparam int DUTY_MAX    = 8191;
    localparam int DUTY_W      = 13;
    localparam int PCT_W       = 8;
    localparam int LEVEL_W     = 7;
    localparam int PCT_FULL    = 100;
    localparam int PCT_HALF    = 50;
    localparam int FADE_INC    = 3;
    localparam int FADE_BOTTOM = 5;

    typedef enum logic [2:0] {
        CMD_STEP_UP   = 3'd0,
        CMD_STEP_DOWN = 3'd1,
        CMD_FADE_TICK = 3'd2,
        CMD_SET_COLD  = 3'd3,
        CMD_SET_WARM  = 3'd4,
        CMD_SET_BOTH  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        PRESET_OFF       = 2'd0,
        PRESET_COLD_FULL = 2'd1,
        PRESET_WARM_FULL = 2'd2,
        PRESET_BOTH_HALF = 2'd3
    } preset_t;

    typedef struct packed {
        preset_t             preset;
        logic                dual_mode;
        logic                cold_selected;
        logic [LEVEL_W-1:0]  fade_level;
        logic                fade_falling;
        logic [DUTY_W-1:0]   cold_duty;
        logic [DUTY_W-1:0]   warm_duty;
    } dim_state_t;

    typedef logic [0:PCT_FULL][DUTY_W-1:0] duty_lut_t;

    // floor(DUTY_MAX * p / 100) for p = 0..100, kept to the duty width
    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        for (int i = 0; i <= PCT_FULL; i++)
        begin
            lut[i] = DUTY_W'((DUTY_MAX * i) / PCT_FULL);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

`default_nettype wire

/* rtl/dldc_step.sv */
// Next-state logic of the dimmer: presets, fade triangle, direct set and update flags.
// Purely combinational; uses dldc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dldc_step (
    input  dldc_pkg::dim_state_t          cur,
    input  logic [2:0]                    cmd,
    input  logic [dldc_pkg::PCT_W-1:0]    cold_percent,
    input  logic [dldc_pkg::PCT_W-1:0]    warm_percent,
    output dldc_pkg::dim_state_t          nxt,
    output logic                          cold_update,
    output logic                          warm_update
);

    localparam int LW = dldc_pkg::LEVEL_W;

    logic                       cold_drive;
    logic                       warm_drive;
    logic [LW-1:0]              cold_pct;
    logic [LW-1:0]              warm_pct;
    logic [LW-1:0]              peak;
    logic [LW-1:0]              lvl;
    logic                       dual;
    logic [dldc_pkg::DUTY_W-1:0] cold_new;
    logic [dldc_pkg::DUTY_W-1:0] warm_new;
    dldc_pkg::preset_t          preset_new;

    // percents above full scale saturate; result indexes the duty table
    function automatic logic [LW-1:0] pct_sat(input logic [dldc_pkg::PCT_W-1:0] p);
        if (p > dldc_pkg::PCT_W'(dldc_pkg::PCT_FULL))
            return LW'(dldc_pkg::PCT_FULL);
        else
            return p[LW-1:0];
    endfunction

    always_comb
    begin
        nxt        = cur;
        cold_drive = 1'b0;
        warm_drive = 1'b0;
        cold_pct   = '0;
        warm_pct   = '0;
        peak       = cur.dual_mode ? LW'(dldc_pkg::PCT_HALF) : LW'(dldc_pkg::PCT_FULL);
        lvl        = cur.fade_level;
        dual       = cur.dual_mode;
        preset_new = cur.preset;

        case (cmd)
            dldc_pkg::CMD_STEP_UP, dldc_pkg::CMD_STEP_DOWN:
            begin
                if (cmd == dldc_pkg::CMD_STEP_UP)
                    preset_new = dldc_pkg::preset_t'(cur.preset + 2'd1);
                else
                    preset_new = dldc_pkg::preset_t'(cur.preset - 2'd1);
                nxt.preset = preset_new;
                cold_drive = 1'b1;
                warm_drive = 1'b1;
                // fade direction is kept across a preset load
                case (preset_new)
                    dldc_pkg::PRESET_OFF:
                    begin
                        nxt.dual_mode     = 1'b0;
                        nxt.fade_level    = '0;
                        nxt.cold_selected = 1'b1;
                    end
                    dldc_pkg::PRESET_COLD_FULL:
                    begin
                        nxt.dual_mode     = 1'b0;
                        nxt.fade_level    = LW'(dldc_pkg::PCT_FULL);
                        nxt.cold_selected = 1'b1;
                        cold_pct          = LW'(dldc_pkg::PCT_FULL);
                    end
                    dldc_pkg::PRESET_WARM_FULL:
                    begin
                        nxt.dual_mode     = 1'b0;
                        nxt.fade_level    = LW'(dldc_pkg::PCT_FULL);
                        nxt.cold_selected = 1'b0;
                        warm_pct          = LW'(dldc_pkg::PCT_FULL);
                    end
                    default:
                    begin
                        nxt.dual_mode     = 1'b1;
                        nxt.fade_level    = LW'(dldc_pkg::PCT_HALF);
                        nxt.cold_selected = 1'b1;
                        cold_pct          = LW'(dldc_pkg::PCT_HALF);
                        warm_pct          = LW'(dldc_pkg::PCT_HALF);
                    end
                endcase
            end
            dldc_pkg::CMD_FADE_TICK:
            begin
                if (!cur.fade_falling)
                begin
                    if (cur.fade_level >= peak)
                    begin
                        nxt.fade_falling = 1'b1;
                        lvl = cur.fade_level - LW'(dldc_pkg::FADE_INC);
                    end
                    else
                        lvl = cur.fade_level + LW'(dldc_pkg::FADE_INC);
                end
                else
                begin
                    // bottom of the triangle: turn around and swap single/dual
                    if (cur.fade_level <= LW'(dldc_pkg::FADE_BOTTOM))
                    begin
                        nxt.fade_falling = 1'b0;
                        dual = !cur.dual_mode;
                        lvl  = cur.fade_level + LW'(dldc_pkg::FADE_INC);
                    end
                    else
                        lvl = cur.fade_level - LW'(dldc_pkg::FADE_INC);
                end
                nxt.fade_level = lvl;
                nxt.dual_mode  = dual;
                cold_drive     = 1'b1;
                warm_drive     = 1'b1;
                if (dual)
                begin
                    cold_pct = pct_sat({1'b0, lvl});
                    warm_pct = pct_sat({1'b0, lvl});
                end
                else if (cur.cold_selected)
                    cold_pct = pct_sat({1'b0, lvl});
                else
                    warm_pct = pct_sat({1'b0, lvl});
            end
            dldc_pkg::CMD_SET_COLD:
            begin
                cold_drive = 1'b1;
                cold_pct   = pct_sat(cold_percent);
            end
            dldc_pkg::CMD_SET_WARM:
            begin
                warm_drive = 1'b1;
                warm_pct   = pct_sat(warm_percent);
            end
            dldc_pkg::CMD_SET_BOTH:
            begin
                cold_drive = 1'b1;
                warm_drive = 1'b1;
                cold_pct   = pct_sat(cold_percent);
                warm_pct   = pct_sat(warm_percent);
            end
            default:
            begin
                cold_drive = 1'b0;
            end
        endcase

        cold_new = dldc_pkg::DUTY_LUT[cold_pct];
        warm_new = dldc_pkg::DUTY_LUT[warm_pct];
        if (cold_drive)
            nxt.cold_duty = cold_new;
        if (warm_drive)
            nxt.warm_duty = warm_new;
        cold_update = cold_drive && (cold_new != cur.cold_duty);
        warm_update = warm_drive && (warm_new != cur.warm_duty);
    end

endmodule

`default_nettype wire

/* rtl/dual_led_dimmer_controller.sv */
// Two-channel cold/warm LED dimmer controller, top level.
// Input register, dldc_step next-state logic, state and result registers; uses dldc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: cmd, cold_percent,
//   warm_percent. Output channel (out_valid/out_ready) returns one result word per
//   command: cold_duty, warm_duty, the two update flags and preset_mode.
//   An accepted word passes the input register, then the result register (two register
//   stages); out_valid rises as the word moves into the result register.
//   Throughput: one word per cycle while out_ready is high, set by the single input
//   register stage and the single result register; the dimmer state updates as a word
//   moves into the result register.
//   Stall: when out_ready is low the result holds; one more word waits in the input
//   register, then in_ready drops until the result is taken.
//   Reset (rst_n low): both stages empty, preset off, single mode, cold selected,
//   fade level 5 rising, both duties 0.
//   Unused command codes return the current duties with both flags clear.
`timescale 1ns / 1ps
`default_nettype none

module dual_led_dimmer_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    cmd,
    input  logic [dldc_pkg::PCT_W-1:0]    cold_percent,
    input  logic [dldc_pkg::PCT_W-1:0]    warm_percent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dldc_pkg::DUTY_W-1:0]   cold_duty,
    output logic [dldc_pkg::DUTY_W-1:0]   warm_duty,
    output logic                          cold_update,
    output logic                          warm_update,
    output logic [1:0]                    preset_mode
);

    logic                         in_valid_reg;
    logic [2:0]                   cmd_reg;
    logic [dldc_pkg::PCT_W-1:0]   cold_pct_reg;
    logic [dldc_pkg::PCT_W-1:0]   warm_pct_reg;
    logic                         out_valid_reg;
    logic                         cold_upd_reg;
    logic                         warm_upd_reg;
    logic                         cold_upd_next;
    logic                         warm_upd_next;
    dldc_pkg::dim_state_t         state_reg;
    dldc_pkg::dim_state_t         state_next;
    logic                         advance;

    // result slot free or being emptied this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dldc_step u_step (
        .cur          (state_reg),
        .cmd          (cmd_reg),
        .cold_percent (cold_pct_reg),
        .warm_percent (warm_pct_reg),
        .nxt          (state_next),
        .cold_update  (cold_upd_next),
        .warm_update  (warm_upd_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg      <= cmd;
            cold_pct_reg <= cold_percent;
            warm_pct_reg <= warm_percent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            cold_upd_reg            <= 1'b0;
            warm_upd_reg            <= 1'b0;
            state_reg.preset        <= dldc_pkg::PRESET_OFF;
            state_reg.dual_mode     <= 1'b0;
            state_reg.cold_selected <= 1'b1;
            state_reg.fade_level    <= dldc_pkg::LEVEL_W'(dldc_pkg::FADE_BOTTOM);
            state_reg.fade_falling  <= 1'b0;
            state_reg.cold_duty     <= '0;
            state_reg.warm_duty     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                cold_upd_reg  <= cold_upd_next;
                warm_upd_reg  <= warm_upd_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // state only moves when the result slot is free, so it doubles as the result word
    assign out_valid   = out_valid_reg;
    assign cold_duty   = state_reg.cold_duty;
    assign warm_duty   = state_reg.warm_duty;
    assign cold_update = cold_upd_reg;
    assign warm_update = warm_upd_reg;
    assign preset_mode = state_reg.preset;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for dual_led_dimmer_controller: presets, fade ticks, direct sets, unused codes.
// Predicts each result word from a behavioral dimmer model and checks it; uses dldc_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 12;

    typedef struct {
        logic [dldc_pkg::DUTY_W-1:0] cold_duty;
        logic [dldc_pkg::DUTY_W-1:0] warm_duty;
        logic                        cold_update;
        logic                        warm_update;
        logic [1:0]                  preset_mode;
    } dim_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] cmd;
    logic [dldc_pkg::PCT_W-1:0] cold_percent;
    logic [dldc_pkg::PCT_W-1:0] warm_percent;
    logic out_valid;
    logic out_ready;
    logic [dldc_pkg::DUTY_W-1:0] cold_duty;
    logic [dldc_pkg::DUTY_W-1:0] warm_duty;
    logic cold_update;
    logic warm_update;
    logic [1:0] preset_mode;

    // dimmer state as the testbench sees it
    logic [1:0]                   preset_q;
    logic                         dual_q;
    logic                         cold_sel_q;
    logic [dldc_pkg::LEVEL_W-1:0] level_q;
    logic                         falling_q;
    logic [dldc_pkg::DUTY_W-1:0]  cold_q;
    logic [dldc_pkg::DUTY_W-1:0]  warm_q;
    logic                         cold_chg;
    logic                         warm_chg;

    dim_result_t expected_words[$];
    int errors;
    int n_results;
    int n_steps;
    int n_fades;
    int n_sets;
    int n_spare;
    int dual_flips;
    logic no_idle;

    dual_led_dimmer_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .cold_percent (cold_percent),
        .warm_percent (warm_percent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cold_duty    (cold_duty),
        .warm_duty    (warm_duty),
        .cold_update  (cold_update),
        .warm_update  (warm_update),
        .preset_mode  (preset_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [dldc_pkg::DUTY_W-1:0] duty_for_pct(input int unsigned p);
        int unsigned sat;
        sat = (p > dldc_pkg::PCT_FULL) ? dldc_pkg::PCT_FULL : p;
        return dldc_pkg::DUTY_W'((dldc_pkg::DUTY_MAX * sat) / dldc_pkg::PCT_FULL);
    endfunction

    task automatic set_cold_level(input int unsigned p);
        logic [dldc_pkg::DUTY_W-1:0] d;
        d = duty_for_pct(p);
        if (d != cold_q)
        begin
            cold_q   = d;
            cold_chg = 1'b1;
        end
    endtask

    task automatic set_warm_level(input int unsigned p);
        logic [dldc_pkg::DUTY_W-1:0] d;
        d = duty_for_pct(p);
        if (d != warm_q)
        begin
            warm_q   = d;
            warm_chg = 1'b1;
        end
    endtask

    task automatic apply_preset();
        case (dldc_pkg::preset_t'(preset_q))
            dldc_pkg::PRESET_OFF:
            begin
                dual_q = 1'b0; level_q = '0; cold_sel_q = 1'b1;
                set_cold_level(0); set_warm_level(0);
            end
            dldc_pkg::PRESET_COLD_FULL:
            begin
                dual_q = 1'b0; cold_sel_q = 1'b1;
                level_q = dldc_pkg::LEVEL_W'(dldc_pkg::PCT_FULL);
                set_cold_level(dldc_pkg::PCT_FULL); set_warm_level(0);
            end
            dldc_pkg::PRESET_WARM_FULL:
            begin
                dual_q = 1'b0; cold_sel_q = 1'b0;
                level_q = dldc_pkg::LEVEL_W'(dldc_pkg::PCT_FULL);
                set_cold_level(0); set_warm_level(dldc_pkg::PCT_FULL);
            end
            default:
            begin
                dual_q = 1'b1; cold_sel_q = 1'b1;
                level_q = dldc_pkg::LEVEL_W'(dldc_pkg::PCT_HALF);
                set_cold_level(dldc_pkg::PCT_HALF); set_warm_level(dldc_pkg::PCT_HALF);
            end
        endcase
    endtask

    task automatic advance_fade();
        int unsigned peak;
        peak = dual_q ? dldc_pkg::PCT_HALF : dldc_pkg::PCT_FULL;
        if (!falling_q)
        begin
            if (level_q >= peak)
            begin
                falling_q = 1'b1;
                level_q   = level_q - dldc_pkg::LEVEL_W'(dldc_pkg::FADE_INC);
            end
            else
                level_q = level_q + dldc_pkg::LEVEL_W'(dldc_pkg::FADE_INC);
        end
        else if (level_q <= dldc_pkg::FADE_BOTTOM)
        begin
            // bottom of the triangle: turn around and swap single/dual
            falling_q = 1'b0;
            dual_q    = ~dual_q;
            level_q   = level_q + dldc_pkg::LEVEL_W'(dldc_pkg::FADE_INC);
            dual_flips++;
        end
        else
            level_q = level_q - dldc_pkg::LEVEL_W'(dldc_pkg::FADE_INC);

        if (dual_q)
        begin
            set_cold_level(level_q); set_warm_level(level_q);
        end
        else if (cold_sel_q)
        begin
            set_cold_level(level_q); set_warm_level(0);
        end
        else
        begin
            set_cold_level(0); set_warm_level(level_q);
        end
    endtask

    // runs one accepted command word through the model, queues its result
    task automatic predict_dimmer(input logic [2:0] c, input logic [7:0] cp,
                                  input logic [7:0] wp);
        dim_result_t r;
        cold_chg = 1'b0;
        warm_chg = 1'b0;
        case (c)
            dldc_pkg::CMD_STEP_UP:
            begin
                preset_q = preset_q + 2'd1; apply_preset(); n_steps++;
            end
            dldc_pkg::CMD_STEP_DOWN:
            begin
                preset_q = preset_q - 2'd1; apply_preset(); n_steps++;
            end
            dldc_pkg::CMD_FADE_TICK:
            begin
                advance_fade(); n_fades++;
            end
            dldc_pkg::CMD_SET_COLD:
            begin
                set_cold_level(cp); n_sets++;
            end
            dldc_pkg::CMD_SET_WARM:
            begin
                set_warm_level(wp); n_sets++;
            end
            dldc_pkg::CMD_SET_BOTH:
            begin
                set_cold_level(cp); set_warm_level(wp); n_sets++;
            end
            default: n_spare++;
        endcase
        r.cold_duty   = cold_q;
        r.warm_duty   = warm_q;
        r.cold_update = cold_chg;
        r.warm_update = warm_chg;
        r.preset_mode = preset_q;
        expected_words.push_back(r);
    endtask

    // drives one word and returns at the edge that accepts it; valid stays high
    task automatic send_word(input logic [2:0] c, input logic [7:0] cp, input logic [7:0] wp);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        cold_percent <= cp;
        warm_percent <= wp;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        predict_dimmer(c, cp, wp);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic logic [7:0] pick_pct();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return 8'($urandom_range(0, dldc_pkg::PCT_FULL));
        else if (sel < 75)
            return 8'($urandom_range(dldc_pkg::PCT_FULL - 1, dldc_pkg::PCT_FULL + 1));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // hold the sender until every queued result has been returned
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_spare_codes();
        send_word(CMD_SPARE6, 8'hFF, 8'h00);
        send_word(CMD_SPARE7, 8'h00, 8'hFF);
    endtask

    task automatic test_reset_fade();
        // level starts at 5 rising, cold selected
        send_word(dldc_pkg::CMD_FADE_TICK, 8'd0, 8'd0);
    endtask

    task automatic test_preset_walk();
        repeat (4) send_word(dldc_pkg::CMD_STEP_UP, pick_pct(), pick_pct());
        repeat (4) send_word(dldc_pkg::CMD_STEP_DOWN, pick_pct(), pick_pct());
    endtask

    task automatic test_direct_set();
        send_word(dldc_pkg::CMD_SET_COLD, 8'd100, 8'd0);
        send_word(dldc_pkg::CMD_SET_COLD, 8'd101, 8'd0);
        send_word(dldc_pkg::CMD_SET_COLD, 8'd255, 8'd0);
        send_word(dldc_pkg::CMD_SET_COLD, 8'd0, 8'd255);
        send_word(dldc_pkg::CMD_SET_WARM, 8'd0, 8'd255);
        send_word(dldc_pkg::CMD_SET_WARM, 8'd255, 8'd1);
        send_word(dldc_pkg::CMD_SET_BOTH, 8'd100, 8'd50);
        send_word(dldc_pkg::CMD_SET_BOTH, 8'hAA, 8'h55);
        send_word(dldc_pkg::CMD_SET_BOTH, 8'd127, 8'd128);
    endtask

    task automatic test_fade_turnaround();
        send_word(dldc_pkg::CMD_STEP_UP, 8'd0, 8'd0);
        repeat (2) send_word(dldc_pkg::CMD_FADE_TICK, 8'd0, 8'd0);
        repeat (2) send_word(dldc_pkg::CMD_STEP_DOWN, 8'd0, 8'd0);
        repeat (2) send_word(dldc_pkg::CMD_FADE_TICK, 8'd0, 8'd0);
    endtask

    // mostly a preset step followed by a run of fade ticks, mixed with sets, short fade runs and noise
    task automatic random_traffic(input int n);
        int k;
        int run;
        int unsigned sel;
        k = 0;
        while (k < n)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
            begin
                send_word($urandom_range(1) ? dldc_pkg::CMD_STEP_UP : dldc_pkg::CMD_STEP_DOWN,
                          8'($urandom), 8'($urandom));
                run = $urandom_range(1, 80);
                repeat (run) send_word(dldc_pkg::CMD_FADE_TICK, 8'($urandom), 8'($urandom));
                k += run + 1;
            end
            else if (sel < 70)
            begin
                case ($urandom_range(2))
                    0: send_word(dldc_pkg::CMD_SET_COLD, pick_pct(), pick_pct());
                    1: send_word(dldc_pkg::CMD_SET_WARM, pick_pct(), pick_pct());
                    default: send_word(dldc_pkg::CMD_SET_BOTH, pick_pct(), pick_pct());
                endcase
                k++;
            end
            else if (sel < 85)
            begin
                run = $urandom_range(1, 10);
                repeat (run) send_word(dldc_pkg::CMD_FADE_TICK, pick_pct(), pick_pct());
                k += run;
            end
            else
            begin
                send_word(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
                k++;
            end
        end
    endtask

    task automatic test_random_mix();
        random_traffic(650);
    endtask

    task automatic test_burst_no_stall();
        no_idle = 1'b1;
        random_traffic(220);
        no_idle = 1'b0;
    endtask

    // result checker
    initial
    begin : result_checker
        dim_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                n_results++;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected result word", 1, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (cold_duty !== want.cold_duty)
                        report_mismatch("cold_duty", cold_duty, want.cold_duty);
                    if (warm_duty !== want.warm_duty)
                        report_mismatch("warm_duty", warm_duty, want.warm_duty);
                    if (cold_update !== want.cold_update)
                        report_mismatch("cold_update", cold_update, want.cold_update);
                    if (warm_update !== want.warm_update)
                        report_mismatch("warm_update", warm_update, want.warm_update);
                    if (preset_mode !== want.preset_mode)
                        report_mismatch("preset_mode", preset_mode, want.preset_mode);
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = '0;
        cold_percent = '0;
        warm_percent = '0;
        no_idle      = 1'b0;
        errors       = 0;
        n_results    = 0;
        n_steps      = 0;
        n_fades      = 0;
        n_sets       = 0;
        n_spare      = 0;
        dual_flips   = 0;
        preset_q     = dldc_pkg::PRESET_OFF;
        dual_q       = 1'b0;
        cold_sel_q   = 1'b1;
        level_q      = dldc_pkg::LEVEL_W'(dldc_pkg::FADE_BOTTOM);
        falling_q    = 1'b0;
        cold_q       = '0;
        warm_q       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_spare_codes();
        test_reset_fade();
        test_preset_walk();
        test_direct_set();
        test_fade_turnaround();
        drain_results();
        test_random_mix();
        drain_results();
        test_burst_no_stall();
        drain_results();
        repeat (8) @(posedge clk);

        $display("run covered %0d preset steps, %0d fade ticks (%0d single/dual swaps),",
                 n_steps, n_fades, dual_flips);
        $display("%0d direct sets and %0d unused codes; %0d result words checked",
                 n_sets, n_spare, n_results);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
